// ===== design/pds_pkg.sv =====
// Shared types and codes for the periodic deadline scheduler.
// Used by pds_cell and the core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pds_pkg;

    // command codes
    localparam logic [2:0] CMD_ADD_KEY = 3'd0;
    localparam logic [2:0] CMD_ADD_TOK = 3'd1;
    localparam logic [2:0] CMD_EN_KEY  = 3'd2;
    localparam logic [2:0] CMD_EN_TOK  = 3'd3;
    localparam logic [2:0] CMD_PAUSE   = 3'd4;
    localparam logic [2:0] CMD_NEXT    = 3'd5;
    localparam logic [2:0] CMD_MARK    = 3'd6;

    // status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_INVALID  = 4'd1;
    localparam logic [3:0] ST_FULL     = 4'd2;
    localparam logic [3:0] ST_DUP      = 4'd3;
    localparam logic [3:0] ST_NOTFOUND = 4'd4;
    localparam logic [3:0] ST_READY    = 4'd5;
    localparam logic [3:0] ST_WAITING  = 4'd6;
    localparam logic [3:0] ST_PAUSED   = 4'd7;
    localparam logic [3:0] ST_EMPTY    = 4'd8;

    // configuration register indexes
    localparam logic CFG_OBD_PROTOCOL = 1'b0;
    localparam logic CFG_OBD_MODULE   = 1'b1;

    // one job table entry
    typedef struct packed {
        logic        is_token;
        logic [7:0]  protocol;
        logic [7:0]  module_id;
        logic [31:0] identifier;
        logic [31:0] token;
        logic [31:0] period;
        logic [63:0] deadline;
        logic [1:0]  prio;
        logic        en;
        logic [7:0]  pid;
        logic        pid_ok;
    } t_job;

endpackage
`default_nettype wire

// ===== design/pds_cell.sv =====
// One cell of the rotating job ring: holds one table entry.
// Depends on pds_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module pds_cell (
    input  wire           i_clk,
    input  wire           i_shift,
    input  pds_pkg::t_job i_next,
    input  wire           i_poke,
    input  pds_pkg::t_job i_poke_job,
    output pds_pkg::t_job o_job
);
    import pds_pkg::*;

    t_job r_job;

    // direct write wins, otherwise take the neighbor's entry while rotating
    always_ff @(posedge i_clk) begin
        if (i_poke) begin
            r_job <= i_poke_job;
        end else if (i_shift) begin
            r_job <= i_next;
        end
    end

    assign o_job = r_job;

endmodule
`default_nettype wire

// ===== design/pds_rem.sv =====
// Bit-serial remainder unit: 64-bit dividend by 32-bit divisor, one bit a cycle.
// Does not use pds_pkg; no instances.
`timescale 1ns / 1ps
`default_nettype none
module pds_rem (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_num,
    input  wire  [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [31:0] r_den;
    logic [31:0] r_rem;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_num[63]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= 32'(w_trial - {1'b0, r_den});
            end else begin
                r_rem <= w_trial[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== design/periodic_deadline_scheduler_core.sv =====
// Top level of the periodic deadline scheduler: controller and ring of job cells.
// Depends on pds_pkg, pds_cell and pds_rem.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    tuser cmd, tdata command fields
//  m_*       out        m_tvalid/m_tready    tuser status, tdata result fields
//  cfg       in         i_cfg_valid/ready    i_cfg_index, i_cfg_data
//
// Each command makes the job ring turn once in full past the head cell in S_SCAN, then
// ends in the finish step S_FIN. Mark dispatched on a due job also passes through S_DIV
// for the bit-serial remainder unit. One command is in flight at a time; the finish step
// waits while a result is still held on m_*. Reset is synchronous; table entries are
// not cleared and only entries below the job count are ever used.
`timescale 1ns / 1ps
`default_nettype none
module periodic_deadline_scheduler_core #(
    parameter int MAX_JOBS = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // command stream
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata: key_protocol, key_module, key_identifier, job_token, period_ms,
    //        job_priority, time_ms, flag, entry_index
    input  wire  [183:0] s_tdata,
    input  wire  [2:0]   s_tuser,   // cmd
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata: sel_index, sel_is_token, sel_protocol, sel_module, sel_identifier,
    //        sel_pid, sel_pid_valid, sel_token, due_ms, wait_ms, one zero pad bit
    output logic [223:0] m_tdata,
    output logic [3:0]   m_tuser,   // status
    // configuration writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire          i_cfg_index,
    input  wire  [7:0]   i_cfg_data
);
    import pds_pkg::*;

    localparam int IDXW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNTW = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_DIV} t_state;

    t_state r_state;

    // control state
    logic [CNTW-1:0] r_count;
    logic            r_paused;
    logic [63:0]     r_pause_start;
    logic [7:0]      r_obd_pr;
    logic [7:0]      r_obd_mo;
    logic            r_mvalid;
    logic [IDXW-1:0] r_k;

    // captured request
    logic [2:0]  r_cmd;
    logic [7:0]  r_pr;
    logic [7:0]  r_mo;
    logic [31:0] r_id;
    logic [31:0] r_tok;
    logic [31:0] r_per;
    logic [1:0]  r_prio;
    logic [63:0] r_t;
    logic        r_flag;
    logic [4:0]  r_ei;
    logic        r_pid_ok;
    logic        r_resume;
    logic [63:0] r_dur;

    // scan results
    logic            r_found;
    logic [IDXW-1:0] r_fidx;
    t_job            r_frec;
    logic            r_any;
    logic [63:0]     r_earliest;
    logic            r_due;
    logic [IDXW-1:0] r_bidx;
    t_job            r_brec;
    t_job            r_mrec;
    logic            r_mdone;

    // output register
    logic [3:0]   r_o_status;
    logic [222:0] r_o_data;
    logic [222:0] n_o_data;

    // request fields
    logic [7:0]  w_pr;
    logic [7:0]  w_mo;
    logic [31:0] w_id;
    logic [31:0] w_tok;
    logic [31:0] w_per;
    logic [1:0]  w_prio;
    logic [63:0] w_t;
    logic        w_flag;
    logic [4:0]  w_ei;
    logic        w_acc;

    assign w_pr   = s_tdata[7:0];
    assign w_mo   = s_tdata[15:8];
    assign w_id   = s_tdata[47:16];
    assign w_tok  = s_tdata[79:48];
    assign w_per  = s_tdata[111:80];
    assign w_prio = s_tdata[113:112];
    assign w_t    = s_tdata[177:114];
    assign w_flag = s_tdata[178];
    assign w_ei   = s_tdata[183:179];

    assign s_tready    = (r_state == S_IDLE);
    assign w_acc       = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    // job ring
    t_job            w_cell [MAX_JOBS];
    t_job            w_ring [MAX_JOBS];
    t_job            w_head;
    t_job            w_tail;
    logic            w_shift;
    logic            w_poke_we;
    logic [IDXW-1:0] w_poke_idx;
    t_job            w_poke_rec;
    logic [64:0]     w_rsum;

    assign w_shift = (r_state == S_SCAN);
    assign w_head  = w_cell[0];

    // head entry on its way to the tail: shifted by the pause time on resume
    logic w_hv;
    assign w_hv   = 32'(r_k) < 32'(r_count);
    assign w_rsum = {1'b0, w_head.deadline} + {1'b0, r_dur};
    always_comb begin
        w_tail = w_head;
        if (r_resume && w_hv) begin
            w_tail.deadline = w_rsum[64] ? '1 : w_rsum[63:0];
        end
    end

    for (genvar gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
        if (gi == MAX_JOBS - 1) begin : g_last
            assign w_ring[gi] = w_tail;
        end else begin : g_mid
            assign w_ring[gi] = w_cell[gi + 1];
        end
        pds_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_shift),
            .i_next     (w_ring[gi]),
            .i_poke     (w_poke_we && (w_poke_idx == IDXW'(gi))),
            .i_poke_job (w_poke_rec),
            .o_job      (w_cell[gi])
        );
    end

    // per-cycle head checks
    logic w_match;
    logic w_en;
    logic w_isdue;
    logic w_better;
    always_comb begin
        if (r_cmd[0]) begin
            w_match = w_hv && w_head.is_token && (w_head.token == r_tok);
        end else begin
            w_match = w_hv && !w_head.is_token && (w_head.protocol == r_pr) &&
                      (w_head.module_id == r_mo) && (w_head.identifier == r_id);
        end
        w_en     = w_hv && w_head.en;
        w_isdue  = w_en && (w_head.deadline <= r_t);
        w_better = w_isdue && (!r_due || (w_head.deadline < r_brec.deadline) ||
                   ((w_head.deadline == r_brec.deadline) && (w_head.prio > r_brec.prio)));
    end

    // remainder unit for the deadline advance
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_rem;
    logic [64:0] w_adv;

    pds_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_t - r_mrec.deadline),
        .i_den   (r_mrec.period),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    // now - remainder + period is the first step past now
    assign w_adv = {1'b0, r_t} - {33'b0, w_rem} + {33'b0, r_mrec.period};

    // finish step decisions
    logic        w_fin;
    logic [3:0]  w_status;
    logic        w_cnt_inc;
    logic        w_go_div;
    logic        w_inv_add;
    logic        w_inv_key;
    t_job        w_new;

    assign w_fin = (r_state == S_FIN) && (!r_mvalid || m_tready);

    always_comb begin
        w_inv_key = r_cmd[0] ? (r_tok == 32'd0) : (r_pr == 8'd0);
        w_inv_add = w_inv_key || (r_per == 32'd0);
        w_new.is_token   = r_cmd[0];
        w_new.protocol   = r_cmd[0] ? 8'd0 : r_pr;
        w_new.module_id  = r_cmd[0] ? 8'd0 : r_mo;
        w_new.identifier = r_cmd[0] ? 32'd0 : r_id;
        w_new.token      = r_cmd[0] ? r_tok : 32'd0;
        w_new.period     = r_per;
        w_new.deadline   = r_t;
        w_new.prio       = r_prio;
        w_new.en         = 1'b1;
        w_new.pid_ok     = r_pid_ok;
        w_new.pid        = r_pid_ok ? r_id[7:0] : 8'd0;
    end

    always_comb begin
        w_status   = ST_INVALID;
        w_cnt_inc  = 1'b0;
        w_go_div   = 1'b0;
        w_poke_we  = 1'b0;
        w_poke_idx = IDXW'(r_count);
        w_poke_rec = w_new;
        unique case (r_cmd)
            CMD_ADD_KEY, CMD_ADD_TOK: begin
                if (w_inv_add) begin
                    w_status = ST_INVALID;
                end else if (r_found) begin
                    w_status = ST_DUP;
                end else if (32'(r_count) >= 32'(MAX_JOBS)) begin
                    w_status = ST_FULL;
                end else begin
                    w_status  = ST_OK;
                    w_cnt_inc = 1'b1;
                    w_poke_we = 1'b1;
                end
            end
            CMD_EN_KEY, CMD_EN_TOK: begin
                if (w_inv_key) begin
                    w_status = ST_INVALID;
                end else if (!r_found) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_status      = ST_OK;
                    w_poke_we     = 1'b1;
                    w_poke_idx    = r_fidx;
                    w_poke_rec    = r_frec;
                    w_poke_rec.en = r_flag;
                end
            end
            CMD_PAUSE: w_status = ST_OK;
            CMD_NEXT: begin
                if (r_paused) begin
                    w_status = ST_PAUSED;
                end else if (!r_any) begin
                    w_status = ST_EMPTY;
                end else if (!r_due) begin
                    w_status = ST_WAITING;
                end else begin
                    w_status = ST_READY;
                end
            end
            CMD_MARK: begin
                if (32'(r_ei) >= 32'(r_count)) begin
                    w_status = ST_INVALID;
                end else if (r_mdone) begin
                    w_status   = ST_OK;
                    w_poke_we  = 1'b1;
                    w_poke_idx = IDXW'(r_ei);
                    w_poke_rec = r_mrec;
                end else if (r_mrec.deadline <= r_t) begin
                    w_go_div = 1'b1;
                end else begin
                    w_status = ST_OK;
                end
            end
            default: w_status = ST_INVALID;
        endcase
        w_poke_we = w_poke_we && w_fin;
    end

    assign w_div_start = w_fin && w_go_div;

    // state machine and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_paused      <= 1'b0;
            r_pause_start <= '0;
            r_obd_pr      <= 8'd1;
            r_obd_mo      <= 8'd1;
            r_mvalid      <= 1'b0;
            r_k           <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OBD_PROTOCOL: r_obd_pr <= i_cfg_data;
                    CFG_OBD_MODULE:   r_obd_mo <= i_cfg_data;
                    default:          r_obd_pr <= r_obd_pr;
                endcase
            end
            if (r_mvalid && m_tready && !(w_fin && !w_go_div)) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_k     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_k == IDXW'(MAX_JOBS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_FIN: begin
                    if (w_fin) begin
                        if (w_go_div) begin
                            r_state <= S_DIV;
                        end else begin
                            r_mvalid <= 1'b1;
                            r_state  <= S_IDLE;
                            if (w_cnt_inc) begin
                                r_count <= r_count + 1'b1;
                            end
                            if (r_cmd == CMD_PAUSE && r_flag != r_paused) begin
                                r_paused      <= r_flag;
                                r_pause_start <= r_flag ? r_t : 64'd0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd      <= s_tuser;
            r_pr       <= w_pr;
            r_mo       <= w_mo;
            r_id       <= w_id;
            r_tok      <= w_tok;
            r_per      <= w_per;
            r_prio     <= w_prio;
            r_t        <= w_t;
            r_flag     <= w_flag;
            r_ei       <= w_ei;
            // only keyed jobs can be diagnostic PIDs
            r_pid_ok   <= !s_tuser[0] && (w_pr == r_obd_pr) && (w_mo == r_obd_mo) &&
                          (w_id <= 32'd255);
            r_resume   <= (s_tuser == CMD_PAUSE) && r_paused && !w_flag;
            r_dur      <= (w_t >= r_pause_start) ? (w_t - r_pause_start) : 64'd0;
            r_found    <= 1'b0;
            r_any      <= 1'b0;
            r_due      <= 1'b0;
            r_mdone    <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (w_match && !r_found) begin
                r_found <= 1'b1;
                r_fidx  <= r_k;
                r_frec  <= w_head;
            end
            if (w_en) begin
                r_any <= 1'b1;
                if (!r_any || (w_head.deadline < r_earliest)) begin
                    r_earliest <= w_head.deadline;
                end
            end
            if (w_better) begin
                r_due  <= 1'b1;
                r_bidx <= r_k;
                r_brec <= w_head;
            end
            if (w_hv && (32'(r_k) == 32'(r_ei))) begin
                r_mrec <= w_head;
            end
        end else if (r_state == S_DIV && w_div_done) begin
            r_mrec.deadline <= w_adv[64] ? '1 : w_adv[63:0];
            r_mdone         <= 1'b1;
        end
    end

    // result fields for the finishing command
    always_comb begin
        n_o_data = '0;
        if (w_status == ST_READY) begin
            n_o_data[4:0]    = 5'(r_bidx);
            n_o_data[5]      = r_brec.is_token;
            n_o_data[13:6]   = r_brec.protocol;
            n_o_data[21:14]  = r_brec.module_id;
            n_o_data[53:22]  = r_brec.identifier;
            n_o_data[61:54]  = r_brec.pid;
            n_o_data[62]     = r_brec.pid_ok;
            n_o_data[94:63]  = r_brec.token;
            n_o_data[158:95] = r_brec.deadline;
        end else if (w_status == ST_WAITING) begin
            n_o_data[158:95]  = r_earliest;
            n_o_data[222:159] = r_earliest - r_t;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_fin && !w_go_div) begin
            r_o_status <= w_status;
            r_o_data   <= n_o_data;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tuser  = r_o_status;
    assign m_tdata  = {1'b0, r_o_data};

    // job count never passes the table size
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_JOBS))
        else $error("job count above table size");

    // job count only ever grows by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("job count jumped");

    // a waiting result always reports a positive wait
    a_wait_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_o_status == ST_WAITING) |-> (r_o_data[222:159] != 64'd0))
        else $error("waiting result with zero wait");

endmodule
`default_nettype wire
